FILE: hdl/dsfc_pkg.sv
package dsfc_pkg;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Byte offsets inside the sound register window.
	localparam logic [5:0] OFF_CTL0       = 6'd0;
	localparam logic [5:0] OFF_CTL1       = 6'd1;
	localparam logic [5:0] OFF_START_HI   = 6'd3;
	localparam logic [5:0] OFF_START_MID  = 6'd5;
	localparam logic [5:0] OFF_START_LO   = 6'd7;
	localparam logic [5:0] OFF_CNT_HI     = 6'd9;
	localparam logic [5:0] OFF_CNT_MID    = 6'd11;
	localparam logic [5:0] OFF_CNT_LO     = 6'd13;
	localparam logic [5:0] OFF_END_HI     = 6'd15;
	localparam logic [5:0] OFF_END_MID    = 6'd17;
	localparam logic [5:0] OFF_END_LO     = 6'd19;
	localparam logic [5:0] OFF_MW_DATA_HI = 6'd34;
	localparam logic [5:0] OFF_MW_DATA_LO = 6'd35;
	localparam logic [5:0] OFF_MW_MASK_HI = 6'd36;
	localparam logic [5:0] OFF_MW_MASK_LO = 6'd37;

	// Control byte bits.
	localparam int CTL_ENABLE_BIT = 0;
	localparam int CTL_REPEAT_BIT = 1;

	// Read value for offsets outside the window.
	localparam logic [7:0] RD_OUTSIDE = 8'hFF;

	// Microwire byte selects.
	localparam logic [1:0] MW_SEL_DATA_HI = 2'd0;
	localparam logic [1:0] MW_SEL_DATA_LO = 2'd1;
	localparam logic [1:0] MW_SEL_MASK_HI = 2'd2;
	localparam logic [1:0] MW_SEL_MASK_LO = 2'd3;

	// Bit count at which a microwire transfer is complete.
	localparam logic [4:0] MW_BITS_DONE = 5'd16;

	typedef struct packed {
		logic       wr;
		logic [1:0] sel;
		logic [7:0] wdata;
		logic       tick;
	} mw_ctl_t;

	typedef struct packed {
		logic [15:0] data;
		logic [15:0] mask;
	} mw_view_t;

endpackage

FILE: hdl/dsfc_mw.sv
module dsfc_mw (
	input  logic              clk,
	input  logic              arst_n,
	input  dsfc_pkg::mw_ctl_t ctl,
	output dsfc_pkg::mw_view_t view
);
	import dsfc_pkg::*;

	logic [15:0] data_q;
	logic [15:0] mask_q;
	logic [4:0]  bits_q;
	logic [31:0] rot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
			mask_q <= '0;
			bits_q <= MW_BITS_DONE;
		end else begin
			if (ctl.wr) begin
				case (ctl.sel)
					MW_SEL_DATA_HI: begin
						data_q[15:8] <= ctl.wdata;
						bits_q       <= '0;
					end
					MW_SEL_DATA_LO: begin
						data_q[7:0] <= ctl.wdata;
						bits_q      <= '0;
					end
					MW_SEL_MASK_HI: mask_q[15:8] <= ctl.wdata;
					MW_SEL_MASK_LO: mask_q[7:0]  <= ctl.wdata;
					default: ;
				endcase
			end else if (ctl.tick && bits_q < MW_BITS_DONE) begin
				bits_q <= bits_q + 5'd1;
			end
		end
	end

	// Data shifts out MSB first; once all sixteen bits are gone it reads zero.
	// The mask rotates so that it stays aligned with the data.
	always_comb begin
		rot       = {mask_q, mask_q} << bits_q[3:0];
		view.mask = rot[31:16];
		view.data = bits_q[4] ? 16'h0000 : (data_q << bits_q[3:0]);
	end

endmodule

FILE: hdl/dma_sound_frame_controller_core.sv
// The result of an item is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle; input and output are parted by a single output register,
// so a new item is taken whenever that register is empty or is being drained.
// Reset (arst_n low, asynchronous): register window reads zero, playback disabled and
// parked, active frame at zero, microwire transfer complete. No clearing pass is needed.
module dma_sound_frame_controller_core #(
	parameter int ADDR_BITS = 22,
	parameter int REG_BYTES = 38
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata: reg_offset[5:0], wdata[13:6], byte_tick[14], mw_tick[15]
	input  logic [15:0]                           s_tdata,
	// s_tuser: cmd[1:0]
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// m_tdata: rdata[7:0], playing[8], frame_latched[9], active_start[ADDR_BITS+9:10],
	// active_end[2*ADDR_BITS+9:ADDR_BITS+10], zero padding to whole bytes above
	output logic [((10+2*ADDR_BITS+7)/8)*8-1:0] m_tdata
);
	import dsfc_pkg::*;

	localparam int OUT_W = ((10 + 2*ADDR_BITS + 7) / 8) * 8;
	localparam int PAD_W = OUT_W - (10 + 2*ADDR_BITS);
	localparam int IDX_W = $clog2(REG_BYTES);

	// ------------------------------------------------------------------
	// Input field unpacking and handshake.
	// ------------------------------------------------------------------
	logic [1:0] cmd;
	logic [5:0] reg_offset;
	logic [7:0] wdata;
	logic       byte_tick;
	logic       mw_tick;
	logic       accept;
	logic       inwin;

	assign cmd        = s_tuser;
	assign reg_offset = s_tdata[5:0];
	assign wdata      = s_tdata[13:6];
	assign byte_tick  = s_tdata[14];
	assign mw_tick    = s_tdata[15];

	// The output register takes a new result whenever it is empty or being drained.
	logic out_vld_q;
	assign s_tready = !out_vld_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign inwin    = 32'(reg_offset) < REG_BYTES;

	// ------------------------------------------------------------------
	// Frame state. The frame length and its empty flag are computed once
	// when a frame latches, which keeps the tick path to one add and compare.
	// ------------------------------------------------------------------
	logic [ADDR_BITS-1:0] act_start_q, act_end_q, len_q, frame_offset_q;
	logic                 empty_q, enabled_q, repeat_q, parked_q;
	logic [ADDR_BITS-1:0] act_start_n, act_end_n, len_n, frame_offset_n;
	logic                 empty_n, enabled_n, repeat_n, parked_n;

	// Shadow copies of the window bytes that feed logic directly.
	logic [7:0] start_hi_q, start_mid_q, start_lo_q;
	logic [7:0] end_hi_q, end_mid_q, end_lo_q;
	logic       ctl1_repeat_q;

	logic [23:0]          start_raw, end_raw;
	logic [ADDR_BITS-1:0] staged_start, staged_end, staged_len;
	logic                 staged_empty;
	logic                 live;
	logic                 do_latch;
	logic [ADDR_BITS-1:0] off_inc;

	always_comb begin
		start_raw    = {start_hi_q, start_mid_q, start_lo_q};
		end_raw      = {end_hi_q, end_mid_q, end_lo_q};
		// Staged addresses are forced even and cut to the address width.
		staged_start = {start_raw[ADDR_BITS-1:1], 1'b0};
		staged_end   = {end_raw[ADDR_BITS-1:1], 1'b0};
		staged_len   = staged_end - staged_start;
		staged_empty = staged_end <= staged_start;
		live         = enabled_q && !parked_q;
		off_inc      = frame_offset_q + 1'b1;

		act_start_n    = act_start_q;
		act_end_n      = act_end_q;
		len_n          = len_q;
		empty_n        = empty_q;
		frame_offset_n = frame_offset_q;
		enabled_n      = enabled_q;
		repeat_n       = repeat_q;
		parked_n       = parked_q;
		do_latch       = 1'b0;

		if (accept) begin
			case (cmd)
				CMD_WRITE: begin
					if (inwin && (reg_offset inside {OFF_CTL0, OFF_CTL1})) begin
						repeat_n = wdata[CTL_REPEAT_BIT];
						if (wdata[CTL_ENABLE_BIT]) begin
							// Only a rising enable starts a fresh frame.
							if (!enabled_q) begin
								do_latch = 1'b1;
								parked_n = 1'b0;
							end
							enabled_n = 1'b1;
						end else begin
							enabled_n = 1'b0;
						end
					end
				end
				CMD_TICK: begin
					if (byte_tick && live) begin
						if (empty_q) begin
							// An empty frame parks without latching a new one.
							parked_n = 1'b1;
						end else begin
							frame_offset_n = off_inc;
							if (off_inc >= len_q) begin
								do_latch = 1'b1;
								if (!repeat_q || staged_empty) begin
									parked_n = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end

		if (do_latch) begin
			act_start_n    = staged_start;
			act_end_n      = staged_end;
			len_n          = staged_len;
			empty_n        = staged_empty;
			frame_offset_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_start_q    <= '0;
			act_end_q      <= '0;
			len_q          <= '0;
			empty_q        <= 1'b1;
			frame_offset_q <= '0;
			enabled_q      <= 1'b0;
			repeat_q       <= 1'b0;
			parked_q       <= 1'b1;
		end else begin
			act_start_q    <= act_start_n;
			act_end_q      <= act_end_n;
			len_q          <= len_n;
			empty_q        <= empty_n;
			frame_offset_q <= frame_offset_n;
			enabled_q      <= enabled_n;
			repeat_q       <= repeat_n;
			parked_q       <= parked_n;
		end
	end

	// ------------------------------------------------------------------
	// Register window storage. Every byte lives in a small memory with a
	// valid bit per entry, so a byte never written reads as zero. The bytes
	// that steer the frame logic are also kept in dedicated flops.
	// ------------------------------------------------------------------
	logic                 wr_en;
	logic [IDX_W-1:0]     rd_idx;
	logic [7:0]           mem [REG_BYTES];
	logic [REG_BYTES-1:0] mvalid_q;
	logic [7:0]           mem_s1;
	logic                 mvld_s1;

	assign wr_en  = accept && cmd == CMD_WRITE && inwin;
	assign rd_idx = inwin ? reg_offset[IDX_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (wr_en) begin
				mem[rd_idx] <= wdata;
			end
			mem_s1  <= mem[rd_idx];
			mvld_s1 <= mvalid_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q      <= '0;
			start_hi_q    <= '0;
			start_mid_q   <= '0;
			start_lo_q    <= '0;
			end_hi_q      <= '0;
			end_mid_q     <= '0;
			end_lo_q      <= '0;
			ctl1_repeat_q <= 1'b0;
		end else if (wr_en) begin
			mvalid_q[rd_idx] <= 1'b1;
			case (reg_offset)
				OFF_CTL1:      ctl1_repeat_q <= wdata[CTL_REPEAT_BIT];
				OFF_START_HI:  start_hi_q    <= wdata;
				OFF_START_MID: start_mid_q   <= wdata;
				OFF_START_LO:  start_lo_q    <= wdata;
				OFF_END_HI:    end_hi_q      <= wdata;
				OFF_END_MID:   end_mid_q     <= wdata;
				OFF_END_LO:    end_lo_q      <= wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Microwire shifter.
	// ------------------------------------------------------------------
	mw_ctl_t  mw_ctl;
	mw_view_t mw_view;

	always_comb begin
		mw_ctl.wr    = wr_en && (reg_offset inside
			{OFF_MW_DATA_HI, OFF_MW_DATA_LO, OFF_MW_MASK_HI, OFF_MW_MASK_LO});
		mw_ctl.sel   = reg_offset[1:0] - OFF_MW_DATA_HI[1:0];
		mw_ctl.wdata = wdata;
		mw_ctl.tick  = accept && cmd == CMD_TICK && mw_tick;
	end

	dsfc_mw u_mw (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mw_ctl),
		.view   (mw_view)
	);

	// ------------------------------------------------------------------
	// Read data. Live views are computed from the state before the item;
	// a read never changes state. Plain bytes come from the memory read
	// and are picked at the output.
	// ------------------------------------------------------------------
	logic [ADDR_BITS-1:0] cnt_sum, fcount;
	logic [23:0]          fc24;
	logic [7:0]           rbyte;
	logic                 rgen;

	always_comb begin
		cnt_sum = act_start_q + frame_offset_q;
		if (!live || empty_q || frame_offset_q >= len_q) begin
			fcount = act_end_q;
		end else begin
			fcount = {cnt_sum[ADDR_BITS-1:1], 1'b0};
		end
		fc24 = 24'(fcount);

		rbyte = 8'h00;
		rgen  = 1'b0;
		if (cmd == CMD_READ) begin
			if (!inwin) begin
				rbyte = RD_OUTSIDE;
			end else begin
				case (reg_offset)
					OFF_CTL1:       rbyte = {6'b0, ctl1_repeat_q, live};
					OFF_CNT_HI:     rbyte = fc24[23:16];
					OFF_CNT_MID:    rbyte = fc24[15:8];
					OFF_CNT_LO:     rbyte = fc24[7:0];
					OFF_MW_DATA_HI: rbyte = mw_view.data[15:8];
					OFF_MW_DATA_LO: rbyte = mw_view.data[7:0];
					OFF_MW_MASK_HI: rbyte = mw_view.mask[15:8];
					OFF_MW_MASK_LO: rbyte = mw_view.mask[7:0];
					default:        rgen  = 1'b1;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic [7:0]           rbyte_s1;
	logic                 rgen_s1, playing_s1, latched_s1;
	logic [ADDR_BITS-1:0] ostart_s1, oend_s1;
	logic [7:0]           rdata_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s_tready) begin
			out_vld_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rbyte_s1   <= rbyte;
			rgen_s1    <= rgen;
			playing_s1 <= enabled_n && !parked_n;
			latched_s1 <= do_latch;
			ostart_s1  <= act_start_n;
			oend_s1    <= act_end_n;
		end
	end

	assign rdata_out = rgen_s1 ? (mvld_s1 ? mem_s1 : 8'h00) : rbyte_s1;
	assign m_tdata   = {{PAD_W{1'b0}}, oend_s1, ostart_s1, latched_s1, playing_s1, rdata_out};

endmodule

FILE: hdl/dsfc_checker.sv
module dsfc_checker #(
	parameter int ADDR_BITS = 22
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((10+2*ADDR_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int START_LSB = 10;
	localparam int END_LSB   = 10 + ADDR_BITS;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Every accepted item yields a result on the next cycle.
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item produced no result");

	// An empty output register never blocks the input.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// Active frame addresses are always even.
	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[START_LSB] && !m_tdata[END_LSB])
		else $error("odd frame address reported");

endmodule

bind dma_sound_frame_controller_core dsfc_checker #(.ADDR_BITS(ADDR_BITS)) u_dsfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
